[hdl/calendar_clock_set_and_advance_macros.svh]
// ----------------------------------------------------------------------------
// calendar clock assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_SET_AND_ADVANCE_MACROS_SVH
`define CALENDAR_CLOCK_SET_AND_ADVANCE_MACROS_SVH

// property holds at every clock edge out of reset
`define CCSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CCSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ccsa_pkg.sv]
// ----------------------------------------------------------------------------
// ccsa_pkg
// types, constants and helpers of the calendar clock
// ----------------------------------------------------------------------------
package ccsa_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;

  // working widths, wide enough for unnormalized sums
  localparam int unsigned YearAccW  = 15;
  localparam int unsigned MonthAccW = 5;
  localparam int unsigned DayAccW   = 7;
  localparam int unsigned QuotW     = 7;

  localparam logic [YearW-1:0]     YEAR_MAX    = 14'd9999;
  localparam logic [MonthAccW-1:0] MONTHS      = 5'd12;
  localparam logic [6:0]           SECS_MIN    = 7'd60;
  localparam logic [6:0]           HOURS_DAY   = 7'd24;
  localparam logic [4:0]           FEB_LEAP    = 5'd29;
  localparam logic [4:0]           LONG_MONTH  = 5'd31;
  localparam logic [3:0]           FEBRUARY    = 4'd2;
  localparam logic [13:0]          CENTURY     = 14'd100;

  // year / 100 as (year * 5243) >> 19, exact for years up to 9999
  localparam logic [12:0]          DIV100_MUL   = 13'd5243;
  localparam int unsigned          Div100Shift  = 19;
  localparam int unsigned          ProdW        = YearW + 13;

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic               action;
    logic [YearW-1:0]   year_value;
    logic [MonthW-1:0]  month_value;
    logic [DayW-1:0]    day_value;
    logic [HourW-1:0]   hour_value;
    logic [MinuteW-1:0] minute_value;
    logic [SecondW-1:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic [YearW-1:0]   cur_year;
    logic [MonthW-1:0]  cur_month;
    logic [DayW-1:0]    cur_day;
    logic [HourW-1:0]   cur_hour;
    logic [MinuteW-1:0] cur_minute;
    logic [SecondW-1:0] cur_second;
    logic               is_set;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FOLD,
    ST_QUOT,
    ST_LEAP,
    ST_DAY,
    ST_CLAMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic set_load;
    logic add_load;
    logic fold;
    logic quot;
    logic leap;
    logic day_step;
    logic day_clamp;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic is_set_action;
    logic set_flag;
    logic month_over;
    logic day_over;
    logic year_wrap;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [1:0] carry;
    logic [6:0] rem;
  } fold_t;

  // value below three times modulus: split into carry and remainder
  function automatic fold_t fold_mod(input logic [6:0] value, input logic [6:0] modulus);
    logic [6:0] twice;
    fold_t      r;
    twice = {modulus[5:0], 1'b0};
    if (value >= twice) begin
      r.carry = 2'd2;
      r.rem   = value - twice;
    end else if (value >= modulus) begin
      r.carry = 2'd1;
      r.rem   = value - modulus;
    end else begin
      r.carry = 2'd0;
      r.rem   = value;
    end
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [3:0] idx;
    idx = month - 4'd1;
    if (month == 4'd0 || month > MONTHS[3:0]) begin
      return LONG_MONTH;
    end else if (month == FEBRUARY && leap) begin
      return FEB_LEAP;
    end
    return MONTH_DAYS[idx];
  endfunction

endpackage

[hdl/ccsa_dp.sv]
// ----------------------------------------------------------------------------
// ccsa_dp
// calendar clock datapath: clock registers, carry logic, leap check, result
// ----------------------------------------------------------------------------
`include "calendar_clock_set_and_advance_macros.svh"

module ccsa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccsa_pkg::in_item_t  in_data_i,
  input  ccsa_pkg::cmd_t      cmd_i,
  output ccsa_pkg::status_t   status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ccsa_pkg::out_item_t out_data_o
);
  import ccsa_pkg::*;

  in_item_t             in_q;
  logic [YearAccW-1:0]  year_q, year_d;
  logic [MonthAccW-1:0] month_q, month_d;
  logic [DayAccW-1:0]   day_q, day_d;
  logic [HourW-1:0]     hour_q, hour_d;
  logic [MinuteW-1:0]   minute_q, minute_d;
  logic [SecondW-1:0]   second_q, second_d;
  logic                 set_q, set_d;
  logic [QuotW-1:0]     quot_q;
  logic                 leap_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  fold_t                sec_f, min_f, hour_f;
  logic [DayAccW-1:0]   day_sum;
  logic [4:0]           len;
  logic                 day_over;
  logic [YearAccW-1:0]  year_sat, year_inc, year_inc_sat;
  logic [ProdW-1:0]     prod;
  logic [YearW-1:0]     hundreds;
  logic                 leap_d;
  logic                 date_ok;
  logic                 time_ok;

  always_comb begin
    sec_f   = fold_mod(7'({1'b0, second_q}) + 7'(in_q.second_value), SECS_MIN);
    min_f   = fold_mod(7'(minute_q) + 7'(in_q.minute_value) + 7'(sec_f.carry), SECS_MIN);
    hour_f  = fold_mod(7'(hour_q) + 7'(in_q.hour_value) + 7'(min_f.carry), HOURS_DAY);
    day_sum = day_q + DayAccW'(in_q.day_value) + DayAccW'(hour_f.carry);
  end

  assign len      = month_len(month_q[MonthW-1:0], leap_q);
  assign day_over = day_q > DayAccW'(len);

  assign year_sat     = (year_q > YearAccW'(YEAR_MAX)) ? YearAccW'(YEAR_MAX) : year_q;
  assign year_inc     = year_q + YearAccW'(1);
  assign year_inc_sat = (year_inc > YearAccW'(YEAR_MAX)) ? YearAccW'(YEAR_MAX) : year_inc;

  // leap check: divisible by 4, and either not a century or a century divisible by 400
  assign prod     = ProdW'(year_q[YearW-1:0]) * ProdW'(DIV100_MUL);
  assign hundreds = YearW'(quot_q) * CENTURY;
  assign leap_d   = (year_q[1:0] == 2'd0) &&
                    ((hundreds != year_q[YearW-1:0]) || (quot_q[1:0] == 2'd0));

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    set_d    = set_q;
    if (cmd_i.set_load) begin
      year_d   = (in_q.year_value > YEAR_MAX) ? YearAccW'(YEAR_MAX)
                                              : YearAccW'(in_q.year_value);
      if (in_q.month_value == 4'd0) begin
        month_d = MonthAccW'(1);
      end else if (MonthAccW'(in_q.month_value) > MONTHS) begin
        month_d = MONTHS;
      end else begin
        month_d = MonthAccW'(in_q.month_value);
      end
      day_d    = DayAccW'(in_q.day_value);
      hour_d   = (in_q.hour_value > 5'd23) ? 5'd23 : in_q.hour_value;
      minute_d = (in_q.minute_value > 6'd59) ? 6'd59 : in_q.minute_value;
      second_d = (in_q.second_value > 6'd59) ? 6'd59 : in_q.second_value;
      set_d    = 1'b1;
    end else if (cmd_i.add_load) begin
      year_d   = year_q + YearAccW'(in_q.year_value);
      month_d  = month_q + MonthAccW'(in_q.month_value);
      day_d    = day_sum;
      hour_d   = hour_f.rem[HourW-1:0];
      minute_d = min_f.rem[MinuteW-1:0];
      second_d = sec_f.rem[SecondW-1:0];
    end else if (cmd_i.fold) begin
      if (month_q > MONTHS) begin
        month_d = month_q - MONTHS;
        year_d  = year_inc;
      end else begin
        year_d  = year_sat;
      end
    end else if (cmd_i.day_step) begin
      if (day_over) begin
        day_d = day_q - DayAccW'(len);
        if (month_q == MONTHS) begin
          month_d = MonthAccW'(1);
          year_d  = year_inc_sat;
        end else begin
          month_d = month_q + MonthAccW'(1);
        end
      end
    end else if (cmd_i.day_clamp) begin
      if (day_q == '0) begin
        day_d = DayAccW'(1);
      end else if (day_over) begin
        day_d = DayAccW'(len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      set_q    <= 1'b0;
    end else begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      set_q    <= set_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.quot) begin
      quot_q <= prod[Div100Shift +: QuotW];
    end
    if (cmd_i.leap) begin
      leap_q <= leap_d;
    end
    if (cmd_i.push) begin
      out_q.cur_year   <= year_q[YearW-1:0];
      out_q.cur_month  <= month_q[MonthW-1:0];
      out_q.cur_day    <= day_q[DayW-1:0];
      out_q.cur_hour   <= hour_q;
      out_q.cur_minute <= minute_q;
      out_q.cur_second <= second_q;
      out_q.is_set     <= set_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.is_set_action = (in_q.action == ACT_SET);
  assign status_o.set_flag      = set_q;
  assign status_o.month_over    = month_q > MONTHS;
  assign status_o.day_over      = day_over;
  assign status_o.year_wrap     = month_q == MONTHS;
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign date_ok = (month_q >= MonthAccW'(1)) && (month_q <= MONTHS) &&
                   (day_q >= DayAccW'(1)) && (year_q <= YearAccW'(YEAR_MAX));
  assign time_ok = (hour_q < 5'd24) && (minute_q < 6'd60) && (second_q < 6'd60);

  `CCSA_ASSERT(a_push_date_ok, !(cmd_i.push && set_q) || date_ok, "pushed date out of range")
  `CCSA_ASSERT(a_push_time_ok, !cmd_i.push || time_ok, "pushed time out of range")
  `CCSA_ASSERT_NEXT(a_push_valid, cmd_i.push, out_valid_q && out_q.is_set == $past(set_q), "result lost")

endmodule

[hdl/ccsa_ctrl.sv]
// ----------------------------------------------------------------------------
// ccsa_ctrl
// calendar clock sequencer: steps set, fold, leap check and day carry
// ----------------------------------------------------------------------------
module ccsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ccsa_pkg::status_t status_i,
  output ccsa_pkg::cmd_t    cmd_o
);
  import ccsa_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_set_action) begin
          state_d = ST_QUOT;
        end else if (status_i.set_flag) begin
          state_d = ST_FOLD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FOLD: begin
        if (!status_i.month_over) begin
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: state_d = ST_LEAP;
      ST_LEAP: begin
        state_d = status_i.is_set_action ? ST_CLAMP : ST_DAY;
      end
      ST_DAY: begin
        // a year wrap changes february, so redo the leap check
        if (!status_i.day_over) begin
          state_d = ST_DONE;
        end else if (status_i.year_wrap) begin
          state_d = ST_QUOT;
        end
      end
      ST_CLAMP: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.set_load = status_i.is_set_action;
        cmd_o.add_load = !status_i.is_set_action && status_i.set_flag;
      end
      ST_FOLD:  cmd_o.fold      = 1'b1;
      ST_QUOT:  cmd_o.quot      = 1'b1;
      ST_LEAP:  cmd_o.leap      = 1'b1;
      ST_DAY:   cmd_o.day_step  = 1'b1;
      ST_CLAMP: cmd_o.day_clamp = 1'b1;
      ST_DONE:  cmd_o.push      = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/calendar_clock_set_and_advance.sv]
// ----------------------------------------------------------------------------
// calendar_clock_set_and_advance
// Gregorian calendar clock with clamped set and carrying add
// ----------------------------------------------------------------------------
// Each accepted item gives one result holding the full date and time after
// it. A set item steps through decode, quotient, leap, clamp and done; an
// add item through decode, fold (again per month fold), quotient, leap, day
// (again per month crossed by the day carry) and done, redoing quotient and
// leap when that carry wraps into a new year. The sequencer folds twelve
// months into a year and steps one month of days per cycle; the leap year
// check registers the quotient by 100 (reciprocal multiply for the century
// test), then the leap flag. An add before any set returns the clock as it is,
// going from decode to done. A new item is taken the cycle after the previous
// result enters the output register, while that result may still wait there.
module calendar_clock_set_and_advance (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ccsa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ccsa_pkg::out_item_t out_data_o
);
  import ccsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  ccsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the calendar clock: directed corner dates, then
// random set/add traffic with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ccsa_pkg::*;

  localparam int unsigned NumRandom = 1200;

  typedef struct {
    bit          drain;
    int unsigned gap;
    in_item_t    item;
  } calendar_op_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  calendar_op_t pending_ops[$];
  out_item_t    expected_dates[$];

  // predicted clock state
  int unsigned cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;
  bit          cal_valid;

  int unsigned mismatches  = 0;
  int unsigned results_got = 0;
  int unsigned wait_left   = 0;
  int unsigned stall_left  = 0;
  bit          in_fire     = 1'b0;
  bit          out_fire    = 1'b0;
  bit          out_waiting = 1'b0;

  calendar_clock_set_and_advance i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    if (y % 400 == 0) begin
      return 1'b1;
    end
    if (y % 100 == 0) begin
      return 1'b0;
    end
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int unsigned clamp_year(int unsigned y);
    return (y > YEAR_MAX) ? int'(YEAR_MAX) : y;
  endfunction

  function automatic out_item_t advance_calendar(in_item_t op);
    int unsigned s, mi, h, d, mo, y, len;
    out_item_t   r;
    if (op.action == ACT_SET) begin
      cal_year   = clamp_year(op.year_value);
      cal_month  = (op.month_value < 1) ? 1 : ((op.month_value > 12) ? 12 : op.month_value);
      len        = days_in_month(cal_month, cal_year);
      cal_day    = (op.day_value < 1) ? 1 : ((op.day_value > len) ? len : op.day_value);
      cal_hour   = (op.hour_value > 23) ? 23 : op.hour_value;
      cal_minute = (op.minute_value > 59) ? 59 : op.minute_value;
      cal_second = (op.second_value > 59) ? 59 : op.second_value;
      cal_valid  = 1'b1;
    end else if (cal_valid) begin
      s  = cal_second + op.second_value;
      mi = cal_minute + op.minute_value + s / 60;
      h  = cal_hour + op.hour_value + mi / 60;
      d  = cal_day + op.day_value + h / 24;
      mo = cal_month + op.month_value;
      y  = cal_year + op.year_value;
      s  = s % 60;
      mi = mi % 60;
      h  = h % 24;
      // months fold into years before the day carry
      while (mo > 12) begin
        mo -= 12;
        y++;
      end
      y = clamp_year(y);
      while (d > days_in_month(mo, y)) begin
        d -= days_in_month(mo, y);
        mo++;
        if (mo > 12) begin
          mo = 1;
          y  = clamp_year(y + 1);
        end
      end
      cal_year   = y;
      cal_month  = mo;
      cal_day    = d;
      cal_hour   = h;
      cal_minute = mi;
      cal_second = s;
    end
    r.cur_year   = cal_year[YearW-1:0];
    r.cur_month  = cal_month[MonthW-1:0];
    r.cur_day    = cal_day[DayW-1:0];
    r.cur_hour   = cal_hour[HourW-1:0];
    r.cur_minute = cal_minute[MinuteW-1:0];
    r.cur_second = cal_second[SecondW-1:0];
    r.is_set     = cal_valid;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_op(bit drain, int unsigned gap, logic act, int unsigned y,
                          int unsigned mo, int unsigned d, int unsigned h,
                          int unsigned mi, int unsigned s);
    calendar_op_t op;
    op.drain             = drain;
    op.gap               = gap;
    op.item.action       = act;
    op.item.year_value   = y[YearW-1:0];
    op.item.month_value  = mo[MonthW-1:0];
    op.item.day_value    = d[DayW-1:0];
    op.item.hour_value   = h[HourW-1:0];
    op.item.minute_value = mi[MinuteW-1:0];
    op.item.second_value = s[SecondW-1:0];
    pending_ops.push_back(op);
  endtask

  // sample both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire     = in_valid_i && !in_stall_o;
      out_fire    = out_valid_o && !out_stall_i;
      out_waiting = out_valid_o;
      if (in_fire) begin
        expected_dates.push_back(advance_calendar(in_data_i));
      end
      if (out_fire) begin
        results_got++;
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected result, year", out_data_o.cur_year, 0);
        end else begin
          out_item_t want;
          want = expected_dates.pop_front();
          if (out_data_o.cur_year !== want.cur_year)
            report_mismatch("year", out_data_o.cur_year, want.cur_year);
          if (out_data_o.cur_month !== want.cur_month)
            report_mismatch("month", out_data_o.cur_month, want.cur_month);
          if (out_data_o.cur_day !== want.cur_day)
            report_mismatch("day", out_data_o.cur_day, want.cur_day);
          if (out_data_o.cur_hour !== want.cur_hour)
            report_mismatch("hour", out_data_o.cur_hour, want.cur_hour);
          if (out_data_o.cur_minute !== want.cur_minute)
            report_mismatch("minute", out_data_o.cur_minute, want.cur_minute);
          if (out_data_o.cur_second !== want.cur_second)
            report_mismatch("second", out_data_o.cur_second, want.cur_second);
          if (out_data_o.is_set !== want.is_set)
            report_mismatch("is_set", out_data_o.is_set, want.is_set);
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    calendar_op_t op;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_ops.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_ops[0].drain && expected_dates.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (wait_left < pending_ops[0].gap) begin
        wait_left++;
        in_valid_i <= 1'b0;
      end else begin
        op = pending_ops.pop_front();
        wait_left = 0;
        in_data_i  <= op.item;
        in_valid_i <= 1'b1;
      end
    end
  end

  // output stall, drawn per result; some stretches run with no stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        stall_left = ((results_got / 128) % 3 == 1) ? 0 : $urandom_range(0, 4);
      end else if (out_waiting && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    int unsigned y, gap;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    cal_year = 0; cal_month = 0; cal_day = 0;
    cal_hour = 0; cal_minute = 0; cal_second = 0;
    cal_valid = 1'b0;

    // add ahead of any set is ignored
    queue_op(0, 0, ACT_ADD, 16383, 15, 31, 31, 63, 63);
    // clamping at the top and bottom of every field
    queue_op(0, 1, ACT_SET, 16383, 15, 31, 31, 63, 63);
    queue_op(0, 0, ACT_ADD, 16383, 15, 31, 31, 63, 63);
    queue_op(0, 2, ACT_SET, 0, 0, 0, 0, 0, 0);
    queue_op(0, 0, ACT_ADD, 0, 0, 0, 0, 0, 0);
    queue_op(0, 0, ACT_SET, 1999, 13, 31, 24, 60, 60);
    // february day clamp across leap rules
    queue_op(0, 3, ACT_SET, 2000, 2, 31, 0, 0, 0);
    queue_op(0, 0, ACT_SET, 1900, 2, 30, 0, 0, 0);
    queue_op(0, 0, ACT_SET, 2023, 2, 29, 0, 0, 0);
    queue_op(0, 4, ACT_SET, 2024, 2, 29, 12, 30, 30);
    // second carry ripples into a leap day, then into march
    queue_op(0, 0, ACT_SET, 2024, 2, 28, 23, 59, 59);
    queue_op(0, 0, ACT_ADD, 0, 0, 0, 0, 0, 1);
    queue_op(0, 1, ACT_ADD, 0, 0, 1, 0, 0, 0);
    queue_op(0, 0, ACT_SET, 2100, 2, 28, 0, 0, 0);
    queue_op(0, 0, ACT_ADD, 0, 0, 1, 0, 0, 0);
    // year saturation on carry into a new year
    queue_op(0, 2, ACT_SET, 9999, 12, 31, 23, 59, 59);
    queue_op(0, 0, ACT_ADD, 0, 0, 0, 0, 0, 1);
    queue_op(0, 0, ACT_SET, 10000, 6, 15, 6, 6, 6);
    // month fold before the day carry
    queue_op(0, 0, ACT_SET, 2023, 11, 30, 0, 0, 0);
    queue_op(0, 0, ACT_ADD, 0, 15, 0, 0, 0, 0);
    queue_op(1, 0, ACT_ADD, 1, 12, 31, 31, 63, 63);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      gap = ((n / 100) % 3 == 0) ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 3))
          0:       y = $urandom_range(0, 16383);
          1:       y = $urandom_range(1583, 2500);
          2:       y = $urandom_range(9990, 9999);
          default: begin
            case ($urandom_range(0, 6))
              0:       y = 0;
              1:       y = 100;
              2:       y = 400;
              3:       y = 1900;
              4:       y = 2000;
              5:       y = 2100;
              default: y = 10000;
            endcase
          end
        endcase
        queue_op(n == 400 || n == 900, gap, ACT_SET, y, $urandom_range(0, 15),
                 $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        // mostly small year steps so dates keep moving below the ceiling
        case ($urandom_range(0, 9))
          0:       y = $urandom_range(0, 16383);
          1, 2:    y = $urandom_range(0, 3);
          default: y = 0;
        endcase
        queue_op(n == 400 || n == 900, gap, ACT_ADD, y, $urandom_range(0, 15),
                 $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_ops.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (expected_dates.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
